// File: hdl/rmq_pkg.sv
// Shared constants, types and datapath step functions for the rotation-matrix to quaternion unit.
package rmq_pkg;

	localparam int ROT_W   = 16;
	localparam int TRN_W   = 32;
	localparam int ONE_Q14 = 16384;

	localparam int CR_W    = 17;  // clamped candidate sum
	localparam int CM_W    = 23;  // candidate root, Q21
	localparam int CS_RAD  = 46;
	localparam int CS_REM  = 25;
	localparam int CS_N    = 23;  // root steps per candidate

	localparam int SQ_W    = 46;
	localparam int SS_W    = 48;  // sum of squares
	localparam int NM_W    = 24;  // norm
	localparam int NS_REM  = 26;
	localparam int NS_N    = 24;

	localparam int NUM_W   = 39;
	localparam int DV_W    = 25;
	localparam int DQ_W    = 15;
	localparam int DR_W    = 26;
	localparam int DQ_N    = 15;

	// Off-diagonal sign bits
	localparam int SG_21M12 = 0;
	localparam int SG_02M20 = 1;
	localparam int SG_10M01 = 2;
	localparam int SG_10P01 = 3;
	localparam int SG_02P20 = 4;
	localparam int SG_21P12 = 5;

	localparam logic [1:0] BIG_W = 2'd0;
	localparam logic [1:0] BIG_X = 2'd1;
	localparam logic [1:0] BIG_Y = 2'd2;
	localparam logic [1:0] BIG_Z = 2'd3;

	typedef struct packed {
		logic [CS_RAD-1:0] rad;
		logic [CM_W-1:0]   root;
		logic [CS_REM-1:0] rem;
	} csq_t;

	typedef struct packed {
		logic [SS_W-1:0]   rad;
		logic [NM_W-1:0]   root;
		logic [NS_REM-1:0] rem;
	} nsq_t;

	typedef struct packed {
		logic [DQ_W-1:0] lo;
		logic [DR_W-1:0] rem;
		logic [DQ_W-1:0] q;
	} div_t;

	typedef struct packed {
		logic [5:0]       sg;
		logic [TRN_W-1:0] tx;
		logic [TRN_W-1:0] ty;
		logic [TRN_W-1:0] tz;
	} side_a_t;

	typedef struct packed {
		logic [3:0][CM_W-1:0] m;
		logic [3:0]           neg;
		logic [TRN_W-1:0]     tx;
		logic [TRN_W-1:0]     ty;
		logic [TRN_W-1:0]     tz;
	} side_b_t;

	typedef struct packed {
		logic [3:0]       neg;
		logic             nz;
		logic [DV_W-1:0]  dv;
		logic [TRN_W-1:0] tx;
		logic [TRN_W-1:0] ty;
		logic [TRN_W-1:0] tz;
	} side_c_t;

	function automatic csq_t csq_step(input csq_t a);
		csq_t r;
		logic [CS_REM-1:0] tmp;
		logic [CS_REM-1:0] trial;
		tmp   = {a.rem[CS_REM-3:0], a.rad[CS_RAD-1 -: 2]};
		trial = {1'b0, a.root[CM_W-2:0], 2'b01};
		r.rad = {a.rad[CS_RAD-3:0], 2'b00};
		if (tmp >= trial) begin
			r.rem  = tmp - trial;
			r.root = {a.root[CM_W-2:0], 1'b1};
		end else begin
			r.rem  = tmp;
			r.root = {a.root[CM_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic nsq_t nsq_step(input nsq_t a);
		nsq_t r;
		logic [NS_REM-1:0] tmp;
		logic [NS_REM-1:0] trial;
		tmp   = {a.rem[NS_REM-3:0], a.rad[SS_W-1 -: 2]};
		trial = {1'b0, a.root[NM_W-2:0], 2'b01};
		r.rad = {a.rad[SS_W-3:0], 2'b00};
		if (tmp >= trial) begin
			r.rem  = tmp - trial;
			r.root = {a.root[NM_W-2:0], 1'b1};
		end else begin
			r.rem  = tmp;
			r.root = {a.root[NM_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_t div_step(input div_t a, input logic [DV_W-1:0] d);
		div_t r;
		logic [DR_W-1:0] tmp;
		tmp  = {a.rem[DR_W-2:0], a.lo[DQ_W-1]};
		r.lo = {a.lo[DQ_W-2:0], 1'b0};
		if (tmp >= {1'b0, d}) begin
			r.rem = tmp - {1'b0, d};
			r.q   = {a.q[DQ_W-2:0], 1'b1};
		end else begin
			r.rem = tmp;
			r.q   = {a.q[DQ_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: hdl/rotation_matrix_to_quaternion_unit.sv
// Pipelined rotation-matrix to unit-quaternion converter with translation pass-through.
// Takes one pose request per cycle while the output is not held, and returns its quaternion
// (w, x, y, z, Q1.14) and translation. The pipeline is built from the bit-serial square-root stages
// (23 for the four candidate roots, 24 for the norm) and the 15 stages of the divider
// that normalizes each component. A held output stalls the whole pipeline in place.
module rotation_matrix_to_quaternion_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_00,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_01,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_02,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_10,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_11,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_12,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_20,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_21,
	input  logic signed [rmq_pkg::ROT_W-1:0]  rot_22,
	input  logic signed [rmq_pkg::TRN_W-1:0]  trans_x_in,
	input  logic signed [rmq_pkg::TRN_W-1:0]  trans_y_in,
	input  logic signed [rmq_pkg::TRN_W-1:0]  trans_z_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rmq_pkg::ROT_W-1:0]  quat_w,
	output logic signed [rmq_pkg::ROT_W-1:0]  quat_x,
	output logic signed [rmq_pkg::ROT_W-1:0]  quat_y,
	output logic signed [rmq_pkg::ROT_W-1:0]  quat_z,
	output logic signed [rmq_pkg::TRN_W-1:0]  trans_x_out,
	output logic signed [rmq_pkg::TRN_W-1:0]  trans_y_out,
	output logic signed [rmq_pkg::TRN_W-1:0]  trans_z_out
);
	import rmq_pkg::*;

	logic en;

	logic signed [ROT_W+1:0] csum [0:3];
	logic [CR_W-1:0]         cclp [0:3];
	logic signed [ROT_W:0]   d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;

	logic    cvld_s [0:CS_N];
	csq_t    cand_s [0:CS_N][0:3];
	side_a_t sa_s   [0:CS_N];

	logic [CM_W-1:0] mr [0:3];
	logic [1:0]      big;
	logic [3:0]      negc;
	logic [5:0]      sgc;

	logic            mvld_s;
	logic [SQ_W-1:0] sq_s [0:3];
	side_b_t         sbm_s;

	logic    nvld_s [0:NS_N];
	nsq_t    norm_s [0:NS_N];
	side_b_t sb_s   [0:NS_N];

	logic [NM_W-1:0]  nrm;
	logic [NUM_W-1:0] numc [0:3];

	logic    dvld_s [0:DQ_N];
	div_t    dv_s   [0:DQ_N][0:3];
	side_c_t sc_s   [0:DQ_N];

	logic [ROT_W-1:0] qres [0:3];

	logic             ovld_s;
	logic [ROT_W-1:0] q_s [0:3];
	logic [TRN_W-1:0] tx_s, ty_s, tz_s;

	assign en       = !(ovld_s && out_stall);
	assign in_stall = !en;

	// candidate sums, clamp below at zero, and off-diagonal signs
	always_comb begin
		csum[0] = 18'sd16384 + 18'(rot_00) + 18'(rot_11) + 18'(rot_22);
		csum[1] = 18'sd16384 + 18'(rot_00) - 18'(rot_11) - 18'(rot_22);
		csum[2] = 18'sd16384 - 18'(rot_00) + 18'(rot_11) - 18'(rot_22);
		csum[3] = 18'sd16384 - 18'(rot_00) - 18'(rot_11) + 18'(rot_22);
		for (int i = 0; i < 4; i++) begin
			cclp[i] = csum[i][ROT_W+1] ? '0 : csum[i][CR_W-1:0];
		end
		d21m12 = 17'(rot_21) - 17'(rot_12);
		d02m20 = 17'(rot_02) - 17'(rot_20);
		d10m01 = 17'(rot_10) - 17'(rot_01);
		s10p01 = 17'(rot_10) + 17'(rot_01);
		s02p20 = 17'(rot_02) + 17'(rot_20);
		s21p12 = 17'(rot_21) + 17'(rot_12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_s[0] <= 1'b0;
		end else if (en) begin
			cvld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				cand_s[0][i].rad  <= {1'b0, cclp[i], 28'b0};
				cand_s[0][i].root <= '0;
				cand_s[0][i].rem  <= '0;
			end
			sa_s[0].sg[SG_21M12] <= d21m12[ROT_W];
			sa_s[0].sg[SG_02M20] <= d02m20[ROT_W];
			sa_s[0].sg[SG_10M01] <= d10m01[ROT_W];
			sa_s[0].sg[SG_10P01] <= s10p01[ROT_W];
			sa_s[0].sg[SG_02P20] <= s02p20[ROT_W];
			sa_s[0].sg[SG_21P12] <= s21p12[ROT_W];
			sa_s[0].tx <= trans_x_in;
			sa_s[0].ty <= trans_y_in;
			sa_s[0].tz <= trans_z_in;
		end
	end

	// candidate roots, one bit per stage
	for (genvar k = 0; k < CS_N; k++) begin : g_cand
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[k+1] <= 1'b0;
			end else if (en) begin
				cvld_s[k+1] <= cvld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					cand_s[k+1][i] <= csq_step(cand_s[k][i]);
				end
				sa_s[k+1] <= sa_s[k];
			end
		end
	end

	// pick the largest root, earliest on a tie, and sign the others
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mr[i] = cand_s[CS_N][i].root;
		end
		sgc = sa_s[CS_N].sg;
		if (mr[0] >= mr[1] && mr[0] >= mr[2] && mr[0] >= mr[3]) begin
			big = BIG_W;
		end else if (mr[1] >= mr[2] && mr[1] >= mr[3]) begin
			big = BIG_X;
		end else if (mr[2] >= mr[3]) begin
			big = BIG_Y;
		end else begin
			big = BIG_Z;
		end
		negc = '0;
		case (big)
			BIG_W: begin
				negc[1] = sgc[SG_21M12];
				negc[2] = sgc[SG_02M20];
				negc[3] = sgc[SG_10M01];
			end
			BIG_X: begin
				negc[0] = sgc[SG_21M12];
				negc[2] = sgc[SG_10P01];
				negc[3] = sgc[SG_02P20];
			end
			BIG_Y: begin
				negc[0] = sgc[SG_02M20];
				negc[1] = sgc[SG_10P01];
				negc[3] = sgc[SG_21P12];
			end
			default: begin
				negc[0] = sgc[SG_10M01];
				negc[1] = sgc[SG_02P20];
				negc[2] = sgc[SG_21P12];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_s    <= 1'b0;
			nvld_s[0] <= 1'b0;
		end else if (en) begin
			mvld_s    <= cvld_s[CS_N];
			nvld_s[0] <= mvld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s[i]    <= mr[i] * mr[i];
				sbm_s.m[i] <= mr[i];
			end
			sbm_s.neg <= negc;
			sbm_s.tx  <= sa_s[CS_N].tx;
			sbm_s.ty  <= sa_s[CS_N].ty;
			sbm_s.tz  <= sa_s[CS_N].tz;

			norm_s[0].rad  <= {2'b0, sq_s[0]} + {2'b0, sq_s[1]}
				+ {2'b0, sq_s[2]} + {2'b0, sq_s[3]};
			norm_s[0].root <= '0;
			norm_s[0].rem  <= '0;
			sb_s[0]        <= sbm_s;
		end
	end

	// norm root, one bit per stage
	for (genvar k = 0; k < NS_N; k++) begin : g_norm
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nvld_s[k+1] <= 1'b0;
			end else if (en) begin
				nvld_s[k+1] <= nvld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				norm_s[k+1] <= nsq_step(norm_s[k]);
				sb_s[k+1]   <= sb_s[k];
			end
		end
	end

	// quotient is (m * 32768 + n) / (2n); it stays below 2^15, so start from the top bits
	always_comb begin
		nrm = norm_s[NS_N].root;
		for (int i = 0; i < 4; i++) begin
			numc[i] = {1'b0, sb_s[NS_N].m[i], 15'b0} + {15'b0, nrm};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s[0] <= 1'b0;
		end else if (en) begin
			dvld_s[0] <= nvld_s[NS_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				dv_s[0][i].lo  <= numc[i][DQ_W-1:0];
				dv_s[0][i].rem <= {2'b0, numc[i][NUM_W-1:DQ_W]};
				dv_s[0][i].q   <= '0;
			end
			sc_s[0].neg <= sb_s[NS_N].neg;
			sc_s[0].nz  <= (nrm != '0);
			sc_s[0].dv  <= {nrm, 1'b0};
			sc_s[0].tx  <= sb_s[NS_N].tx;
			sc_s[0].ty  <= sb_s[NS_N].ty;
			sc_s[0].tz  <= sb_s[NS_N].tz;
		end
	end

	for (genvar k = 0; k < DQ_N; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k+1] <= 1'b0;
			end else if (en) begin
				dvld_s[k+1] <= dvld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 4; i++) begin
					dv_s[k+1][i] <= div_step(dv_s[k][i], sc_s[k].dv);
				end
				sc_s[k+1] <= sc_s[k];
			end
		end
	end

	// saturate, apply sign, zero on a zero norm
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [ROT_W-1:0] mag;
			mag = (dv_s[DQ_N][i].q > DQ_W'(ONE_Q14)) ? ROT_W'(ONE_Q14)
				: {1'b0, dv_s[DQ_N][i].q};
			if (!sc_s[DQ_N].nz) begin
				qres[i] = '0;
			end else if (sc_s[DQ_N].neg[i]) begin
				qres[i] = -mag;
			end else begin
				qres[i] = mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_s <= 1'b0;
		end else if (en) begin
			ovld_s <= dvld_s[DQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				q_s[i] <= qres[i];
			end
			tx_s <= sc_s[DQ_N].tx;
			ty_s <= sc_s[DQ_N].ty;
			tz_s <= sc_s[DQ_N].tz;
		end
	end

	assign out_valid   = ovld_s;
	assign quat_w      = q_s[0];
	assign quat_x      = q_s[1];
	assign quat_y      = q_s[2];
	assign quat_z      = q_s[3];
	assign trans_x_out = tx_s;
	assign trans_y_out = ty_s;
	assign trans_z_out = tz_s;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the rotation-matrix to quaternion unit.
`timescale 1ns / 1ps

module tb;
	import rmq_pkg::*;

	localparam int LATENCY  = 67;
	localparam int WDOG_MAX = 20000;

	typedef struct {
		logic signed [ROT_W-1:0] r [9];
		logic signed [TRN_W-1:0] tx, ty, tz;
	} pose_t;

	typedef struct {
		logic signed [ROT_W-1:0] q [4];
		logic signed [TRN_W-1:0] tx, ty, tz;
	} quat_pose_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [ROT_W-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
	logic signed [ROT_W-1:0] rot_20, rot_21, rot_22;
	logic signed [TRN_W-1:0] trans_x_in, trans_y_in, trans_z_in;
	logic signed [ROT_W-1:0] quat_w, quat_x, quat_y, quat_z;
	logic signed [TRN_W-1:0] trans_x_out, trans_y_out, trans_z_out;

	quat_pose_t pending_quats[$];
	int errors = 0;
	int idle_pct = 6;
	bit hold_off = 0;
	int quiet_cycles = 0;

	rotation_matrix_to_quaternion_unit DUT (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic quat_pose_t convert_pose(pose_t p);
		quat_pose_t e;
		longint c [4];
		longint unsigned m [4];
		longint unsigned ssq = 0, n, mag;
		longint r [9];
		bit neg [4];
		logic [1:0] big;
		for (int i = 0; i < 9; i++) r[i] = p.r[i];
		c[0] = ONE_Q14 + r[0] + r[4] + r[8];
		c[1] = ONE_Q14 + r[0] - r[4] - r[8];
		c[2] = ONE_Q14 - r[0] + r[4] - r[8];
		c[3] = ONE_Q14 - r[0] - r[4] + r[8];
		for (int i = 0; i < 4; i++) begin
			if (c[i] < 0) c[i] = 0;
			m[i] = int_sqrt(longint'(c[i]) << 28);
			neg[i] = 0;
		end
		if (m[0] >= m[1] && m[0] >= m[2] && m[0] >= m[3]) big = BIG_W;
		else if (m[1] >= m[2] && m[1] >= m[3]) big = BIG_X;
		else if (m[2] >= m[3]) big = BIG_Y;
		else big = BIG_Z;
		// r index: row*3+col
		case (big)
			BIG_W: begin
				neg[1] = (r[7] - r[5]) < 0;
				neg[2] = (r[2] - r[6]) < 0;
				neg[3] = (r[3] - r[1]) < 0;
			end
			BIG_X: begin
				neg[0] = (r[7] - r[5]) < 0;
				neg[2] = (r[3] + r[1]) < 0;
				neg[3] = (r[2] + r[6]) < 0;
			end
			BIG_Y: begin
				neg[0] = (r[2] - r[6]) < 0;
				neg[1] = (r[3] + r[1]) < 0;
				neg[3] = (r[7] + r[5]) < 0;
			end
			default: begin
				neg[0] = (r[3] - r[1]) < 0;
				neg[1] = (r[6] + r[2]) < 0;
				neg[2] = (r[7] + r[5]) < 0;
			end
		endcase
		for (int i = 0; i < 4; i++) ssq += m[i] * m[i];
		n = int_sqrt(ssq);
		for (int i = 0; i < 4; i++) begin
			e.q[i] = 0;
			if (n != 0) begin
				mag = (m[i] * ONE_Q14 * 2 + n) / (2 * n);
				if (mag > ONE_Q14) mag = ONE_Q14;
				e.q[i] = neg[i] ? -ROT_W'(mag) : ROT_W'(mag);
			end
		end
		e.tx = p.tx;
		e.ty = p.ty;
		e.tz = p.tz;
		return e;
	endfunction

	task automatic send_pose(pose_t p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid   <= 1;
		{rot_00, rot_01, rot_02} <= {p.r[0], p.r[1], p.r[2]};
		{rot_10, rot_11, rot_12} <= {p.r[3], p.r[4], p.r[5]};
		{rot_20, rot_21, rot_22} <= {p.r[6], p.r[7], p.r[8]};
		trans_x_in <= p.tx;
		trans_y_in <= p.ty;
		trans_z_in <= p.tz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_quats.push_back(convert_pose(p));
	endtask

	task automatic idle_input();
		in_valid <= 0;
		@(posedge clk);
	endtask

	function automatic pose_t random_pose(int mode);
		pose_t p;
		for (int i = 0; i < 9; i++) begin
			case (mode)
				0: p.r[i] = ROT_W'($urandom);
				1: p.r[i] = ROT_W'($signed($urandom_range(32768)) - 16384);
				default: p.r[i] = ($urandom_range(3) == 0) ? ROT_W'(0) :
					(($urandom_range(1) != 0) ? ROT_W'(16384) : ROT_W'(-16384));
			endcase
		end
		p.tx = $urandom;
		p.ty = $urandom;
		p.tz = $urandom;
		return p;
	endfunction

	function automatic pose_t diag_pose(int a, int b, int c, int off);
		pose_t p;
		for (int i = 0; i < 9; i++) p.r[i] = ROT_W'(off);
		p.r[0] = ROT_W'(a);
		p.r[4] = ROT_W'(b);
		p.r[8] = ROT_W'(c);
		p.tx = 32'sh7fffffff;
		p.ty = 32'sh80000000;
		p.tz = 0;
		return p;
	endfunction

	// extremes, each branch of the largest candidate, zero off-diagonals
	task automatic test_directed();
		pose_t p;
		send_pose(diag_pose(16384, 16384, 16384, 0));
		send_pose(diag_pose(16384, -16384, -16384, 0));
		send_pose(diag_pose(-16384, 16384, -16384, 0));
		send_pose(diag_pose(-16384, -16384, 16384, 0));
		send_pose(diag_pose(0, 0, 0, 0));
		send_pose(diag_pose(16384, 16384, 16384, 16384));
		send_pose(diag_pose(16384, -16384, -16384, -16384));
		send_pose(diag_pose(-16384, 16384, -16384, -16384));
		send_pose(diag_pose(-16384, -16384, 16384, -16384));
		send_pose(diag_pose(-32768, -32768, -32768, 32767));
		send_pose(diag_pose(32767, 32767, 32767, -32768));
		send_pose(diag_pose(32767, -32768, -32768, 32767));
		send_pose(diag_pose(-32768, 32767, -32768, -32768));
		send_pose(diag_pose(-32768, -32768, 32767, 32767));
		send_pose(diag_pose(5000, 5000, 5000, 0));  // tie on the x, y and z candidates
		send_pose(diag_pose(-5461, -5461, -5461, 0));
		p = diag_pose(0, 0, 0, 0);
		p.r[1] = 16384; p.r[3] = -16384; p.r[8] = 16384;
		p.tx = -1; p.ty = 1; p.tz = 32'sh55555555;
		send_pose(p);
		p.r[1] = -16384; p.r[3] = 16384; p.tz = 32'shaaaaaaaa;
		send_pose(p);
		p = diag_pose(-16384, -16384, 16384, 0);
		p.r[2] = -100; p.r[6] = -200; p.r[5] = -7; p.r[7] = -9;
		send_pose(p);
		p = diag_pose(16384, -16384, -16384, 0);
		p.r[1] = -3; p.r[3] = 2; p.r[2] = -3; p.r[6] = 1; p.r[5] = 5; p.r[7] = -1;
		send_pose(p);
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++)
			send_pose(random_pose($urandom_range(2)));
	endtask

	task automatic test_no_idle(int count);
		idle_pct = 0;
		test_random(count);
		idle_pct = 6;
	endtask

	// hold the output long enough for the pipeline to fill and stall the input
	task automatic test_backpressure(int count);
		hold_off = 1;
		test_no_idle(count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1;
		else if (hold_off)
			out_stall <= 1;
		else
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
		end
	end

	always @(posedge clk) begin
		quat_pose_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_quats.size() == 0) begin
				$display("%0t: unexpected result w=%0d", $time, quat_w);
				errors++;
			end else begin
				e = pending_quats.pop_front();
				if ({quat_w, quat_x, quat_y, quat_z} !== {e.q[0], e.q[1], e.q[2], e.q[3]} ||
				    {trans_x_out, trans_y_out, trans_z_out} !== {e.tx, e.ty, e.tz}) begin
					$display("%0t: expected q=%0d %0d %0d %0d t=%h %h %h", $time,
						e.q[0], e.q[1], e.q[2], e.q[3], e.tx, e.ty, e.tz);
					$display("%0t: actual   q=%0d %0d %0d %0d t=%h %h %h", $time,
						quat_w, quat_x, quat_y, quat_z,
						trans_x_out, trans_y_out, trans_z_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n     = 0;
		in_valid   = 0;
		{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12} = '0;
		{rot_20, rot_21, rot_22} = '0;
		{trans_x_in, trans_y_in, trans_z_in} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(600);
		test_no_idle(300);
		test_backpressure(200);
		test_random(330);
		idle_input();
		while (pending_quats.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
